// File: hw/rtl/ble_pkg.sv
// Shared types and constants for the bounded list engine.
package ble_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int FUNC_W       = 4;
    localparam int POS_W        = 7;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH_BACK  = 4'd0,
        FUNC_PUSH_FRONT = 4'd1,
        FUNC_POP_BACK   = 4'd2,
        FUNC_POP_FRONT  = 4'd3,
        FUNC_READ       = 4'd4,
        FUNC_WRITE      = 4'd5,
        FUNC_INSERT     = 4'd6,
        FUNC_ERASE      = 4'd7,
        FUNC_CLEAR      = 4'd8
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ERASE  = 2'd2,
        CELL_WRITE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     rd_en;
        logic     last_en;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

endpackage

// File: hw/rtl/ble_cell.sv
// One list slot: holds an element and shifts with its neighbors.
module ble_cell #(
    parameter int CNT_W = 7
) (
    input  logic                         i_clk,
    input  ble_pkg::t_cell_ctl           i_ctl,
    input  logic [CNT_W-1:0]             i_index,
    input  logic [CNT_W-1:0]             i_pos,
    input  logic [CNT_W-1:0]             i_rd_pos,
    input  logic [CNT_W-1:0]             i_last_pos,
    input  logic [ble_pkg::VALUE_W-1:0]  i_value,
    input  logic [ble_pkg::VALUE_W-1:0]  i_left,
    input  logic [ble_pkg::VALUE_W-1:0]  i_right,
    output logic [ble_pkg::VALUE_W-1:0]  o_value,
    output logic [ble_pkg::VALUE_W-1:0]  o_rd_tap,
    output logic [ble_pkg::VALUE_W-1:0]  o_last_tap
);

    logic [ble_pkg::VALUE_W-1:0] r_value;
    logic [ble_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            ble_pkg::CELL_INSERT: begin
                if (i_index > i_pos) begin
                    n_value = i_left;
                end else if (i_index == i_pos) begin
                    n_value = i_value;
                end
            end
            ble_pkg::CELL_ERASE: begin
                if (i_index >= i_pos) begin
                    n_value = i_right;
                end
            end
            ble_pkg::CELL_WRITE: begin
                if (i_index == i_pos) begin
                    n_value = i_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value    = r_value;
    assign o_rd_tap   = (i_ctl.rd_en && (i_index == i_rd_pos)) ? r_value : '0;
    assign o_last_tap = (i_ctl.last_en && (i_index == i_last_pos)) ? r_value : '0;

endmodule

// File: hw/rtl/bounded_list_engine.sv
// Top level: bounded double-ended list built from a chain of shifting cells.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------------
//  in      | i_valid | o_ready | i_func, i_value, i_position
//  out     | o_valid | i_ready | o_read_value, o_status, o_count,
//          |         |         | o_first_value, o_last_value
//
// An item passes through three steps: accept (the cell chain shifts or writes
// as it is taken), evaluate (read, first and last taps gathered across the chain),
// and present. One item is in flight at a time; o_ready is high only when idle.
// A stalled output holds the engine until i_ready. Reset empties the list;
// element storage itself is not cleared.
module bounded_list_engine #(
    parameter int CAPACITY = ble_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [ble_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [ble_pkg::VALUE_W-1:0]  i_value,
    input  logic [ble_pkg::POS_W-1:0]           i_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [ble_pkg::VALUE_W-1:0]  o_read_value,
    output logic [ble_pkg::STATUS_W-1:0]        o_status,
    output logic [ble_pkg::COUNT_W-1:0]         o_count,
    output logic signed [ble_pkg::VALUE_W-1:0]  o_first_value,
    output logic signed [ble_pkg::VALUE_W-1:0]  o_last_value
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > ble_pkg::POS_W) ? CNT_W : ble_pkg::POS_W;
    localparam int VW = ble_pkg::VALUE_W;

    ble_pkg::t_state r_state;
    ble_pkg::t_state n_state;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_rd_pos;
    logic             r_rd_en;
    ble_pkg::t_status r_status;

    logic [VW-1:0]                 r_out_read;
    logic [ble_pkg::STATUS_W-1:0]  r_out_status;
    logic [ble_pkg::COUNT_W-1:0]   r_out_count;
    logic [VW-1:0]                 r_out_first;
    logic [VW-1:0]                 r_out_last;

    logic             w_in_fire;
    logic             w_out_fire;
    logic             w_eval;
    logic             w_full;
    logic             w_empty;
    logic [WIDE_W-1:0] w_pos_x;
    logic [WIDE_W-1:0] w_cnt_x;
    logic [WIDE_W-1:0] w_out_cnt_x;

    ble_pkg::t_cell_op w_dec_op;
    logic [CNT_W-1:0]  w_dec_pos;
    logic              w_dec_rd;
    ble_pkg::t_status  w_dec_status;
    logic [CNT_W-1:0]  w_dec_count;

    ble_pkg::t_cell_ctl w_ctl;
    logic [CNT_W-1:0]   w_last_pos;

    logic [VW-1:0] w_val      [CAPACITY];
    logic [VW-1:0] w_rd_tap   [CAPACITY];
    logic [VW-1:0] w_last_tap [CAPACITY];
    logic [VW-1:0] w_rd_or;
    logic [VW-1:0] w_last_or;

    assign w_in_fire  = i_valid && o_ready;
    assign w_out_fire = o_valid && i_ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_pos_x    = WIDE_W'(i_position);
    assign w_cnt_x    = WIDE_W'(r_count);

    // operation decode against the current count
    always_comb begin
        w_dec_op     = ble_pkg::CELL_HOLD;
        w_dec_pos    = '0;
        w_dec_rd     = 1'b0;
        w_dec_status = ble_pkg::STAT_OK;
        w_dec_count  = r_count;
        case (ble_pkg::t_func'(i_func))
            ble_pkg::FUNC_PUSH_BACK: begin
                if (w_full) begin
                    w_dec_status = ble_pkg::STAT_FULL;
                end else begin
                    w_dec_op    = ble_pkg::CELL_WRITE;
                    w_dec_pos   = r_count;
                    w_dec_count = r_count + CNT_W'(1);
                end
            end
            ble_pkg::FUNC_PUSH_FRONT: begin
                if (w_full) begin
                    w_dec_status = ble_pkg::STAT_FULL;
                end else begin
                    w_dec_op    = ble_pkg::CELL_INSERT;
                    w_dec_count = r_count + CNT_W'(1);
                end
            end
            ble_pkg::FUNC_POP_BACK: begin
                if (w_empty) begin
                    w_dec_status = ble_pkg::STAT_EMPTY;
                end else begin
                    w_dec_count = r_count - CNT_W'(1);
                end
            end
            ble_pkg::FUNC_POP_FRONT: begin
                if (w_empty) begin
                    w_dec_status = ble_pkg::STAT_EMPTY;
                end else begin
                    w_dec_op    = ble_pkg::CELL_ERASE;
                    w_dec_count = r_count - CNT_W'(1);
                end
            end
            ble_pkg::FUNC_READ: begin
                if (w_empty) begin
                    w_dec_status = ble_pkg::STAT_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_dec_status = ble_pkg::STAT_RANGE;
                end else begin
                    w_dec_rd  = 1'b1;
                    w_dec_pos = w_pos_x[CNT_W-1:0];
                end
            end
            ble_pkg::FUNC_WRITE: begin
                if (w_empty) begin
                    w_dec_status = ble_pkg::STAT_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_dec_status = ble_pkg::STAT_RANGE;
                end else begin
                    w_dec_op  = ble_pkg::CELL_WRITE;
                    w_dec_pos = w_pos_x[CNT_W-1:0];
                end
            end
            ble_pkg::FUNC_INSERT: begin
                if (w_full) begin
                    w_dec_status = ble_pkg::STAT_FULL;
                end else if (w_pos_x > w_cnt_x) begin
                    w_dec_status = ble_pkg::STAT_RANGE;
                end else begin
                    w_dec_op    = ble_pkg::CELL_INSERT;
                    w_dec_pos   = w_pos_x[CNT_W-1:0];
                    w_dec_count = r_count + CNT_W'(1);
                end
            end
            ble_pkg::FUNC_ERASE: begin
                if (w_empty) begin
                    w_dec_status = ble_pkg::STAT_EMPTY;
                end else if (w_pos_x >= w_cnt_x) begin
                    w_dec_status = ble_pkg::STAT_RANGE;
                end else begin
                    w_dec_op    = ble_pkg::CELL_ERASE;
                    w_dec_pos   = w_pos_x[CNT_W-1:0];
                    w_dec_count = r_count - CNT_W'(1);
                end
            end
            ble_pkg::FUNC_CLEAR: begin
                w_dec_count = '0;
            end
            default: begin
                w_dec_op = ble_pkg::CELL_HOLD;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ble_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = ble_pkg::ST_EVAL;
                end
            end
            ble_pkg::ST_EVAL: begin
                n_state = ble_pkg::ST_OUT;
            end
            ble_pkg::ST_OUT: begin
                if (w_out_fire) begin
                    n_state = ble_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ble_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        w_eval  = 1'b0;
        case (r_state)
            ble_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            ble_pkg::ST_EVAL: begin
                w_eval = 1'b1;
            end
            ble_pkg::ST_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign n_count = w_in_fire ? w_dec_count : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ble_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_rd_en  <= w_dec_rd;
            r_rd_pos <= w_dec_pos;
            r_status <= w_dec_status;
        end
    end

    // cell chain control
    assign w_ctl.op      = w_in_fire ? w_dec_op : ble_pkg::CELL_HOLD;
    assign w_ctl.rd_en   = r_rd_en;
    assign w_ctl.last_en = !w_empty;
    assign w_last_pos    = r_count - CNT_W'(1);

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic [VW-1:0] w_left;
            logic [VW-1:0] w_right;
            if (k == 0) begin : g_head
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_val[k-1];
            end
            if (k == CAPACITY - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_val[k+1];
            end
            ble_cell #(
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_index    (CNT_W'(k)),
                .i_pos      (w_dec_pos),
                .i_rd_pos   (r_rd_pos),
                .i_last_pos (w_last_pos),
                .i_value    (i_value),
                .i_left     (w_left),
                .i_right    (w_right),
                .o_value    (w_val[k]),
                .o_rd_tap   (w_rd_tap[k]),
                .o_last_tap (w_last_tap[k])
            );
        end
    endgenerate

    // at most one cell drives each tap, so the taps combine by OR
    always_comb begin
        w_rd_or   = '0;
        w_last_or = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_rd_or   = w_rd_or | w_rd_tap[j];
            w_last_or = w_last_or | w_last_tap[j];
        end
    end

    assign w_out_cnt_x = WIDE_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (w_eval) begin
            r_out_read   <= w_rd_or;
            r_out_status <= r_status;
            r_out_count  <= w_out_cnt_x[ble_pkg::COUNT_W-1:0];
            r_out_first  <= w_empty ? '0 : w_val[0];
            r_out_last   <= w_last_or;
        end
    end

    assign o_read_value  = r_out_read;
    assign o_status      = r_out_status;
    assign o_count       = r_out_count;
    assign o_first_value = r_out_first;
    assign o_last_value  = r_out_last;

endmodule

// File: tb/ble_tb_pkg.sv
`timescale 1ns / 1ps
// List predictor and result scoreboard for the bounded list engine testbench.
package ble_tb_pkg;
    import ble_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0]  rd;
        t_status             st;
        logic [COUNT_W-1:0]  cnt;
        logic [VALUE_W-1:0]  first_v;
        logic [VALUE_W-1:0]  last_v;
    } t_list_result;

    class list_scoreboard;
        logic [VALUE_W-1:0] cells [CAPACITY_DEF];
        int unsigned        length;
        t_list_result       result_q [$];
        int unsigned        errors;
        int unsigned        noted;
        int unsigned        checked;
        int unsigned        peak;
        int unsigned        stat_seen [4];

        function new();
            length  = 0;
            errors  = 0;
            noted   = 0;
            checked = 0;
            peak    = 0;
            foreach (stat_seen[k]) stat_seen[k] = 0;
        endfunction

        function int unsigned list_length();
            return length;
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        function void open_slot(int unsigned at);
            for (int unsigned k = length; k > at; k--) cells[k] = cells[k-1];
        endfunction

        function void close_slot(int unsigned at);
            for (int unsigned k = at; k + 1 < length; k++) cells[k] = cells[k+1];
        endfunction

        // Apply one accepted operation to the list and queue its result.
        function void note_op(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v,
                              logic [POS_W-1:0] p);
            t_list_result res;
            int unsigned  at;
            res.rd = '0;
            res.st = STAT_OK;
            at     = p;
            case (f)
                FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                    if (length >= CAPACITY_DEF) begin
                        res.st = STAT_FULL;
                    end else if (f == FUNC_PUSH_BACK) begin
                        cells[length] = v;
                        length++;
                    end else begin
                        open_slot(0);
                        cells[0] = v;
                        length++;
                    end
                end
                FUNC_POP_BACK, FUNC_POP_FRONT: begin
                    if (length == 0) begin
                        res.st = STAT_EMPTY;
                    end else begin
                        if (f == FUNC_POP_FRONT) close_slot(0);
                        length--;
                    end
                end
                FUNC_READ, FUNC_WRITE, FUNC_ERASE: begin
                    if (length == 0) begin
                        res.st = STAT_EMPTY;
                    end else if (at >= length) begin
                        res.st = STAT_RANGE;
                    end else if (f == FUNC_READ) begin
                        res.rd = cells[at];
                    end else if (f == FUNC_WRITE) begin
                        cells[at] = v;
                    end else begin
                        close_slot(at);
                        length--;
                    end
                end
                FUNC_INSERT: begin
                    if (length >= CAPACITY_DEF) begin
                        res.st = STAT_FULL;
                    end else if (at > length) begin
                        res.st = STAT_RANGE;
                    end else begin
                        open_slot(at);
                        cells[at] = v;
                        length++;
                    end
                end
                FUNC_CLEAR: begin
                    length = 0;
                end
                default: begin
                end
            endcase
            res.cnt     = COUNT_W'(length);
            res.first_v = (length > 0) ? cells[0] : '0;
            res.last_v  = (length > 0) ? cells[length-1] : '0;
            if (length > peak) peak = length;
            stat_seen[res.st]++;
            noted++;
            result_q = {result_q, res};
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [VALUE_W-1:0] rd, logic [STATUS_W-1:0] st,
                                   logic [COUNT_W-1:0] cnt, logic [VALUE_W-1:0] first_v,
                                   logic [VALUE_W-1:0] last_v);
            t_list_result want;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result: status %0d count %0d", $time, st, cnt);
                errors++;
                return;
            end
            want = result_q[0];
            result_q.delete(0);
            checked++;
            compare_field("read_value", want.rd, rd);
            compare_field("status", VALUE_W'(want.st), VALUE_W'(st));
            compare_field("count", VALUE_W'(want.cnt), VALUE_W'(cnt));
            compare_field("first_value", want.first_v, first_v);
            compare_field("last_value", want.last_v, last_v);
        endfunction
    endclass

endpackage

// File: tb/bounded_list_engine_test.sv
`timescale 1ns / 1ps
// Testbench top: directed and random list operations, every result checked.
module bounded_list_engine_test;
    import ble_pkg::*;
    import ble_tb_pkg::*;

    localparam int RANDOM_ITEMS      = 850;
    localparam int PHASE_LEN         = 85;
    localparam int HOLD_CYCLES       = 200;
    localparam int LIMIT_CYCLES      = 200000;
    localparam int FUNC_FIRST_UNUSED = int'(FUNC_CLEAR) + 1;
    localparam int FUNC_LAST_CODE    = 2**FUNC_W - 1;
    localparam int POS_MAX           = 2**POS_W - 1;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIX
    } t_mix;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [FUNC_W-1:0]          i_func;
    logic signed [VALUE_W-1:0]  i_value;
    logic [POS_W-1:0]           i_position;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [VALUE_W-1:0]  o_read_value;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_count;
    logic signed [VALUE_W-1:0]  o_first_value;
    logic signed [VALUE_W-1:0]  o_last_value;

    list_scoreboard sb;
    bit             idle_off = 1'b0;
    bit             hold_req = 1'b0;
    int unsigned    cycle_count = 0;

    bounded_list_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_count       (o_count),
        .o_first_value (o_first_value),
        .o_last_value  (o_last_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still pending", $time, sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int rx_wait;
        hold_left = 0;
        rx_wait   = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (rx_wait > 0) begin
                i_ready = 1'b0;
                rx_wait--;
            end else begin
                i_ready = 1'b1;
                rx_wait = idle_off ? 0 : gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_read_value, o_status, o_count, o_first_value, o_last_value);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                             input logic [POS_W-1:0] p);
        int gap;
        gap = idle_off ? 0 : gap_len();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_func     = f;
        i_value    = v;
        i_position = p;
        do @(posedge i_clk); while (!o_ready);
        sb.note_op(f, v, p);
        @(negedge i_clk);
    endtask

    function automatic t_mix mode_of(int phase);
        case (phase % 10)
            0, 1, 4, 7: return MODE_GROW;
            2, 6, 9:    return MODE_SHRINK;
            default:    return MODE_MIX;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func(t_mix m);
        t_func       order [9];
        int unsigned w [10];
        int unsigned r;
        int unsigned acc;
        order = '{FUNC_PUSH_BACK, FUNC_PUSH_FRONT, FUNC_POP_BACK, FUNC_POP_FRONT,
                  FUNC_READ, FUNC_WRITE, FUNC_INSERT, FUNC_ERASE, FUNC_CLEAR};
        // last weight: unused codes
        case (m)
            MODE_GROW:   w = '{30, 25, 3, 3, 6, 6, 20, 2, 2, 3};
            MODE_SHRINK: w = '{6, 6, 24, 24, 8, 8, 5, 15, 1, 3};
            default:     w = '{12, 12, 10, 10, 14, 12, 12, 10, 3, 5};
        endcase
        r   = $urandom_range(0, 99);
        acc = 0;
        for (int k = 0; k < 9; k++) begin
            acc += w[k];
            if (r < acc) return order[k];
        end
        return FUNC_W'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_CODE));
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(logic [FUNC_W-1:0] f, int unsigned n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return POS_W'($urandom_range(0, POS_MAX));
        if (r < 25) return POS_W'(n);
        if (f == FUNC_INSERT) return POS_W'($urandom_range(0, n));
        return (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom;
        if (r < 80) return 32'h7FFF_FFFF;
        if (r < 90) return 32'h8000_0000;
        return VALUE_W'($urandom_range(0, 15) - 8);
    endfunction

    initial begin
        logic [FUNC_W-1:0] f;
        t_mix              m;
        sb         = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_func     = '0;
        i_value    = '0;
        i_position = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty list corner cases
        send_item(FUNC_POP_BACK, 32'h0, 7'd0);
        send_item(FUNC_POP_FRONT, 32'h0, 7'd0);
        send_item(FUNC_READ, 32'h0, 7'd0);
        send_item(FUNC_WRITE, 32'h1234_5678, 7'd0);
        send_item(FUNC_ERASE, 32'h0, 7'd0);
        send_item(FUNC_INSERT, 32'h1, 7'd1);
        // build up with value extremes, then reads, writes, erases, unused codes, pops and clears
        send_item(FUNC_INSERT, 32'h7FFF_FFFF, 7'd0);
        send_item(FUNC_PUSH_BACK, 32'h8000_0000, 7'd0);
        send_item(FUNC_PUSH_FRONT, 32'h0, 7'd0);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 7'd3);
        send_item(FUNC_INSERT, 32'h5, 7'd1);
        send_item(FUNC_READ, 32'h0, 7'd4);
        send_item(FUNC_READ, 32'h0, 7'd5);
        send_item(FUNC_READ, 32'h0, 7'd127);
        send_item(FUNC_WRITE, 32'h5555_5555, 7'd0);
        send_item(FUNC_WRITE, 32'hAAAA_AAAA, 7'd127);
        send_item(FUNC_ERASE, 32'h0, 7'd127);
        send_item(FUNC_ERASE, 32'h0, 7'd2);
        send_item(FUNC_ERASE, 32'h0, 7'd0);
        send_item(FUNC_W'(FUNC_FIRST_UNUSED), 32'hAAAA_AAAA, 7'd127);
        send_item(FUNC_W'(FUNC_LAST_CODE), 32'h5555_5555, 7'd0);
        send_item(FUNC_POP_BACK, 32'h0, 7'd0);
        send_item(FUNC_POP_FRONT, 32'h0, 7'd0);
        send_item(FUNC_CLEAR, 32'h0, 7'd0);
        send_item(FUNC_CLEAR, 32'h0, 7'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            m        = mode_of(i / PHASE_LEN);
            idle_off = ((i / PHASE_LEN) % 4) == 3;
            if (i == 2 * PHASE_LEN - 30) hold_req = 1'b1;
            f = pick_func(m);
            send_item(f, pick_value(), pick_pos(f, sb.list_length()));
        end
        i_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("Ran %0d list operations, %0d results checked, longest list %0d of %0d.",
                 sb.noted, sb.checked, sb.peak, CAPACITY_DEF);
        $display("Statuses predicted: ok %0d, empty %0d, out of range %0d, full %0d.",
                 sb.stat_seen[STAT_OK], sb.stat_seen[STAT_EMPTY],
                 sb.stat_seen[STAT_RANGE], sb.stat_seen[STAT_FULL]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ble_pkg.sv
hw/rtl/ble_cell.sv
hw/rtl/bounded_list_engine.sv
tb/ble_tb_pkg.sv
tb/bounded_list_engine_test.sv
